// ===== sv/mime_transfer_decoder_unit_macros.svh =====
// Assertion macros for the MIME transfer decoder.
`ifndef MIME_TRANSFER_DECODER_UNIT_MACROS_SVH
`define MIME_TRANSFER_DECODER_UNIT_MACROS_SVH
`ifndef SYNTH
`define MTD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtd: same-cycle check failed");
`define MTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtd: next-cycle check failed");
`else
`define MTD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define MTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/mtd_pkg.sv =====
// Package: codes, character constants, lookup functions and types of the decoder.
`default_nettype none
package mtd_pkg;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_BASE64 = 2'd1;
   localparam logic [1:0] MODE_QPRINT = 2'd2;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

   // one group of decoded bytes; bytes[0] leaves first
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } grp_type;

   // {valid, sextet}
   function automatic logic [6:0] b64_lookup(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = {1'b1, 6'(c - CHAR_UPPER_A)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r = {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
      end else if (c == CHAR_PLUS) begin
         r = {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   // {valid, nibble}; uppercase hex only
   function automatic logic [4:0] hex_lookup(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r = {1'b1, 4'(c - CHAR_DIGIT_0)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r = {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/mtd_channels_if.sv =====
// Valid/ready channel interfaces for encoded input and decoded output beats.
`default_nettype none
interface mtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       part_start;
   modport source (output valid, output in_byte, output part_start, input ready);
   modport sink (input valid, input in_byte, input part_start, output ready);
endinterface

interface mtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/mtd_decode.sv =====
// Input register, decoder state and single-pass decode of one byte into a group.
`default_nettype none
module mtd_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       mode,
   input  wire logic             in_valid,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_part_start,
   output logic                  in_ready,
   input  wire logic             grp_free,
   output logic                  grp_load,
   output mtd_pkg::grp_type      grp,
   output logic                  stg_valid
);

   logic        stg_valid_ff, stg_valid_in;
   logic [7:0]  stg_byte_ff;
   logic        stg_start_ff;

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [2:0]  pad_ff, pad_in;
   logic        esc_ff, esc_in;
   logic        seen_ff, seen_in;
   logic [3:0]  nib_ff, nib_in;

   logic        advance;

   always_comb begin
      logic [23:0] acc_e;
      logic [1:0]  cnt_e;
      logic [2:0]  pad_e;
      logic        esc_e, seen_e;
      logic [3:0]  nib_e;
      logic [6:0]  b64;
      logic [4:0]  hex;
      logic        is_eq, took;
      logic [23:0] acc_sh;
      logic [2:0]  pad_inc;

      // part start clears state ahead of this byte
      acc_e  = stg_start_ff ? '0 : acc_ff;
      cnt_e  = stg_start_ff ? '0 : cnt_ff;
      pad_e  = stg_start_ff ? '0 : pad_ff;
      esc_e  = stg_start_ff ? 1'b0 : esc_ff;
      seen_e = stg_start_ff ? 1'b0 : seen_ff;
      nib_e  = stg_start_ff ? '0 : nib_ff;

      b64     = mtd_pkg::b64_lookup(stg_byte_ff);
      hex     = mtd_pkg::hex_lookup(stg_byte_ff);
      is_eq   = (stg_byte_ff == mtd_pkg::CHAR_EQUALS);
      took    = is_eq || b64[6];
      acc_sh  = {acc_e[17:0], (is_eq ? 6'd0 : b64[5:0])};
      pad_inc = pad_e + {2'd0, is_eq};

      acc_in  = acc_e;
      cnt_in  = cnt_e;
      pad_in  = pad_e;
      esc_in  = esc_e;
      seen_in = seen_e;
      nib_in  = nib_e;
      grp.bytes = {16'd0, stg_byte_ff};
      grp.count = 2'd0;

      unique case (mode)
         mtd_pkg::MODE_BASE64: begin
            if (took) begin
               if (cnt_e == 2'd3) begin
                  case (pad_inc)
                     3'd0:    grp.count = 2'd3;
                     3'd1:    grp.count = 2'd2;
                     3'd2:    grp.count = 2'd1;
                     default: grp.count = 2'd0;
                  endcase
                  grp.bytes = {acc_sh[7:0], acc_sh[15:8], acc_sh[23:16]};
                  acc_in = '0;
                  cnt_in = '0;
                  pad_in = '0;
               end else begin
                  acc_in = acc_sh;
                  cnt_in = cnt_e + 2'd1;
                  pad_in = pad_inc;
               end
            end
         end
         mtd_pkg::MODE_QPRINT: begin
            if (esc_e) begin
               if (hex[4]) begin
                  if (seen_e) begin
                     grp.bytes = {16'd0, nib_e, hex[3:0]};
                     grp.count = 2'd1;
                     esc_in  = 1'b0;
                     seen_in = 1'b0;
                     nib_in  = '0;
                  end else begin
                     nib_in  = hex[3:0];
                     seen_in = 1'b1;
                  end
               end
            end else if (is_eq) begin
               esc_in  = 1'b1;
               seen_in = 1'b0;
               nib_in  = '0;
            end else begin
               grp.count = 2'd1;
            end
         end
         default: begin
            grp.count = 2'd1;
         end
      endcase
   end

   // a byte that yields nothing retires without waiting for the buffer
   assign advance      = stg_valid_ff && (grp.count == 2'd0 || grp_free);
   assign grp_load     = advance && (grp.count != 2'd0);
   assign in_ready     = !stg_valid_ff || advance;
   assign stg_valid_in = in_valid || (stg_valid_ff && !advance);
   assign stg_valid    = stg_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         pad_ff  <= '0;
         esc_ff  <= 1'b0;
         seen_ff <= 1'b0;
         nib_ff  <= '0;
      end else begin
         stg_valid_ff <= in_ready ? stg_valid_in : stg_valid_ff;
         if (advance) begin
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_in;
            pad_ff  <= pad_in;
            esc_ff  <= esc_in;
            seen_ff <= seen_in;
            nib_ff  <= nib_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stg_byte_ff  <= in_byte;
         stg_start_ff <= in_part_start;
      end
   end

endmodule
`default_nettype wire

// ===== sv/mtd_out_buf.sv =====
// Result register: holds one group of decoded bytes and sends it a beat at a time.
`default_nettype none
module mtd_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             grp_load,
   input  wire mtd_pkg::grp_type grp,
   output logic                  grp_free,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [7:0]            out_byte,
   output logic                  out_last
);

   logic [1:0]      cnt_ff, cnt_in;
   logic [2:0][7:0] bytes_ff, bytes_in;
   logic            pop;

   assign pop      = (cnt_ff != 2'd0) && out_ready;
   assign grp_free = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      if (grp_load) begin
         cnt_in   = grp.count;
         bytes_in = grp.bytes;
      end else if (pop) begin
         // advance to the next byte of the group
         cnt_in   = cnt_ff - 2'd1;
         bytes_in = {8'd0, bytes_ff[2], bytes_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_byte  = bytes_ff[0];
   assign out_last  = (cnt_ff == 2'd1);

endmodule
`default_nettype wire

// ===== sv/mime_transfer_decoder_unit.sv =====
// Top level of the MIME transfer decoder: mode register, decode stage, result buffer.
//
//   channel   direction  beat content             handshake
//   req_if    in         in_byte, part_start      valid/ready
//   rsp_if    out        out_byte, last           valid/ready
//   csr_*     in         decode_mode (2 bits)     write enable, no wait
//
// One encoded byte is accepted per cycle unless the result buffer stalls decode; its first
// decoded byte is offered once it has passed the stage register and the result buffer.
// Output runs at one byte per cycle while rsp_if is ready, so a full base64 quantum (three
// bytes) holds the result buffer until its last byte is taken and sets the sustained rate.
// Bytes that decode to nothing retire without waiting for or touching the buffer.
// Reset clears the mode and all decoder state; a stalled rsp_if backs up into req_if.
`default_nettype none
`include "mime_transfer_decoder_unit_macros.svh"
module mime_transfer_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data,
   mtd_req_if.sink         req_if,
   mtd_rsp_if.source       rsp_if
);

   logic [1:0]       mode_ff;
   logic             grp_free;
   logic             grp_load;
   logic             stg_valid;
   mtd_pkg::grp_type grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mtd_pkg::MODE_PASS;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   mtd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .in_valid      (req_if.valid),
      .in_byte       (req_if.in_byte),
      .in_part_start (req_if.part_start),
      .in_ready      (req_if.ready),
      .grp_free      (grp_free),
      .grp_load      (grp_load),
      .grp           (grp),
      .stg_valid     (stg_valid)
   );

   mtd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .grp_load  (grp_load),
      .grp       (grp),
      .grp_free  (grp_free),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_byte  (rsp_if.out_byte),
      .out_last  (rsp_if.last)
   );

   `MTD_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_if.valid && req_if.ready, stg_valid)
   `MTD_ASSERT_IMPLIES(a_load_only_when_free, clock, reset, grp_load, grp_free && stg_valid)
   `MTD_ASSERT_NEXT(a_last_beat_empties, clock, reset, rsp_if.valid && rsp_if.ready && rsp_if.last && !grp_load, !rsp_if.valid)
   `MTD_ASSERT_NEXT(a_load_shows_beat, clock, reset, grp_load, rsp_if.valid)

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the MIME transfer decoder: pass-through, base64 and QP modes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // mode 3 is unused and decodes as pass-through
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   typedef enum {RX_STEADY, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_style_type;

   class mime_decode_tracker;
      logic [1:0]   mode;
      logic [23:0]  sextets;
      logic [1:0]   sextet_count;
      logic [2:0]   pad_count;
      logic         escaping;
      logic         nibble_held;
      logic [3:0]   high_nibble;
      out_beat_type owed[$];
      int           beats_in;
      int           beats_out;
      int           failures;
      int           reported;

      function new();
         mode      = mtd_pkg::MODE_PASS;
         beats_in  = 0;
         beats_out = 0;
         failures  = 0;
         reported  = 0;
         clear();
      endfunction

      function void clear();
         sextets      = '0;
         sextet_count = '0;
         pad_count    = '0;
         escaping     = 1'b0;
         nibble_held  = 1'b0;
         high_nibble  = '0;
      endfunction

      // {in alphabet, sextet}
      static function logic [6:0] sextet_of(input logic [7:0] c);
         logic [7:0] v;
         v = 8'hFF;
         if (c inside {[mtd_pkg::CHAR_UPPER_A:mtd_pkg::CHAR_UPPER_Z]})
            v = c - mtd_pkg::CHAR_UPPER_A;
         else if (c inside {[mtd_pkg::CHAR_LOWER_A:mtd_pkg::CHAR_LOWER_Z]})
            v = c - mtd_pkg::CHAR_LOWER_A + 8'd26;
         else if (c inside {[mtd_pkg::CHAR_DIGIT_0:mtd_pkg::CHAR_DIGIT_9]})
            v = c - mtd_pkg::CHAR_DIGIT_0 + 8'd52;
         else if (c == mtd_pkg::CHAR_PLUS) v = 8'd62;
         else if (c == mtd_pkg::CHAR_SLASH) v = 8'd63;
         return {v != 8'hFF, v[5:0]};
      endfunction

      // {is uppercase hex, nibble}
      static function logic [4:0] nibble_of(input logic [7:0] c);
         logic [7:0] v;
         v = 8'hFF;
         if (c inside {[mtd_pkg::CHAR_DIGIT_0:mtd_pkg::CHAR_DIGIT_9]})
            v = c - mtd_pkg::CHAR_DIGIT_0;
         else if (c inside {[mtd_pkg::CHAR_UPPER_A:mtd_pkg::CHAR_UPPER_F]})
            v = c - mtd_pkg::CHAR_UPPER_A + 8'd10;
         return {v != 8'hFF, v[3:0]};
      endfunction

      function void complain(input string msg);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("mismatch at %0t: %s", $realtime, msg);
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void take_encoded(input logic [7:0] c, input logic ps);
         logic [7:0]   grp [3];
         logic [6:0]   sx;
         logic [4:0]   nb;
         logic         took;
         out_beat_type b;
         int           n;
         n    = 0;
         took = 1'b0;
         beats_in++;
         if (ps) clear();
         sx = sextet_of(c);
         nb = nibble_of(c);
         case (mode)
            mtd_pkg::MODE_BASE64: begin
               if (c == mtd_pkg::CHAR_EQUALS) begin
                  sextets = {sextets[17:0], 6'd0};
                  pad_count++;
                  took = 1'b1;
               end else if (sx[6]) begin
                  sextets = {sextets[17:0], sx[5:0]};
                  took = 1'b1;
               end
               if (took) begin
                  if (sextet_count == 2'd3) begin
                     n = (pad_count >= 3'd3) ? 0 : 3 - pad_count;
                     grp[0] = sextets[23:16];
                     grp[1] = sextets[15:8];
                     grp[2] = sextets[7:0];
                     sextets      = '0;
                     sextet_count = '0;
                     pad_count    = '0;
                  end else begin
                     sextet_count++;
                  end
               end
            end
            mtd_pkg::MODE_QPRINT: begin
               if (escaping) begin
                  // drop anything that is not an uppercase hex digit
                  if (nb[4]) begin
                     if (nibble_held) begin
                        grp[0]      = {high_nibble, nb[3:0]};
                        n           = 1;
                        escaping    = 1'b0;
                        nibble_held = 1'b0;
                        high_nibble = '0;
                     end else begin
                        high_nibble = nb[3:0];
                        nibble_held = 1'b1;
                     end
                  end
               end else if (c == mtd_pkg::CHAR_EQUALS) begin
                  escaping    = 1'b1;
                  nibble_held = 1'b0;
                  high_nibble = '0;
               end else begin
                  grp[0] = c;
                  n      = 1;
               end
            end
            default: begin
               grp[0] = c;
               n      = 1;
            end
         endcase
         for (int k = 0; k < n; k++) begin
            b.data = grp[k];
            b.last = (k == n - 1);
            owed = {owed, b};
         end
      endfunction

      function void match_decoded(input logic [7:0] data, input logic last);
         out_beat_type want;
         beats_out++;
         if (owed.size() == 0) begin
            complain($sformatf("unexpected beat %02h last=%0b", data, last));
         end else begin
            want = owed.pop_front();
            if (want.data !== data || want.last !== last)
               complain($sformatf("beat %0d: expected %02h last=%0b, got %02h last=%0b",
                                  beats_out, want.data, want.last, data, last));
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   mtd_req_if req_ch ();
   mtd_rsp_if rsp_ch ();

   mime_transfer_decoder_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_ch.sink),
      .rsp_if      (rsp_ch.source)
   );

   mime_decode_tracker board = new();

   logic [1:0] mode_plan [8] = '{mtd_pkg::MODE_BASE64, mtd_pkg::MODE_PASS,
                                 mtd_pkg::MODE_QPRINT, mtd_pkg::MODE_BASE64,
                                 MODE_SPARE, mtd_pkg::MODE_QPRINT,
                                 mtd_pkg::MODE_BASE64, mtd_pkg::MODE_PASS};
   bit  hold_req;
   int  hold_cycles;
   int  holds_done;
   int  burst_left;
   int  random_items;
   int  modes_written;
   bit  restart;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("timeout at %0t", $realtime);
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.take_encoded(req_ch.in_byte, req_ch.part_start);
         if (rsp_ch.valid && rsp_ch.ready) board.match_decoded(rsp_ch.out_byte, rsp_ch.last);
      end
   end

   // receiver: picks a new random stall style whenever the current run ends, long hold on request
   initial begin
      rx_style_type style;
      int           left;
      int           k;
      rsp_ch.ready = 1'b0;
      style = RX_STEADY;
      left  = 0;
      k     = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_req = 1'b0;
            holds_done++;
         end else begin
            if (left == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               left  = $urandom_range(16, 64);
               k     = 0;
            end
            left--;
            k++;
            case (style)
               RX_STEADY:       rsp_ch.ready <= 1'b1;
               RX_COIN:         rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               RX_EVERY_FOURTH: rsp_ch.ready <= (k % 4 != 0);
               default:         rsp_ch.ready <= ($urandom_range(0, 9) >= 2);
            endcase
         end
      end
   end

   task automatic pause_sender(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic offer(input logic [7:0] c, input logic ps, input bit counted);
      if (burst_left == 0) begin
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= c;
      req_ch.part_start <= ps;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (counted) random_items++;
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0, 1'b0);
   endtask

   // drop valid, wait for every owed beat, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic set_mode(input logic [1:0] m);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      board.mode = m;
      modes_written++;
   endtask

   function automatic logic [7:0] b64_char();
      int i;
      i = $urandom_range(0, 63);
      if (i < 26) return mtd_pkg::CHAR_UPPER_A + 8'(i);
      if (i < 52) return mtd_pkg::CHAR_LOWER_A + 8'(i - 26);
      if (i < 62) return mtd_pkg::CHAR_DIGIT_0 + 8'(i - 52);
      return (i == 62) ? mtd_pkg::CHAR_PLUS : mtd_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [7:0] hex_char();
      int i;
      i = $urandom_range(0, 15);
      return (i < 10) ? mtd_pkg::CHAR_DIGIT_0 + 8'(i) : mtd_pkg::CHAR_UPPER_A + 8'(i - 10);
   endfunction

   // bytes an open escape must discard
   function automatic logic [7:0] escape_junk();
      case ($urandom_range(0, 4))
         0:       return mtd_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
         1:       return 8'h0D;
         2:       return 8'h0A;
         3:       return mtd_pkg::CHAR_EQUALS;
         default: return mtd_pkg::CHAR_UPPER_A + 8'($urandom_range(6, 25));
      endcase
   endfunction

   task automatic b64_unit();
      int   r;
      int   pads;
      logic ps;
      r  = $urandom_range(0, 99);
      ps = restart || ($urandom_range(0, 9) == 0);
      restart = 1'b0;
      if (r < 70) begin
         pads = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 7) == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer((i >= 4 - pads) ? mtd_pkg::CHAR_EQUALS : b64_char(), ps && (i == 0), 1'b1);
         end
      end else if (r < 80) begin
         // pads scattered through the group
         for (int i = 0; i < 4; i++)
            offer(($urandom_range(0, 2) == 0) ? mtd_pkg::CHAR_EQUALS : b64_char(),
                  ps && (i == 0), 1'b1);
      end else if (r < 90) begin
         offer(8'($urandom_range(0, 255)), ps, 1'b0);
      end else begin
         // truncated group; the next one restarts the part
         for (int i = 0; i < $urandom_range(1, 3); i++) offer(b64_char(), 1'b0, 1'b1);
         restart = 1'b1;
      end
   endtask

   task automatic qp_unit();
      int         r;
      logic       ps;
      logic [7:0] c;
      r  = $urandom_range(0, 99);
      ps = restart;
      restart = 1'b0;
      if (r < 55) begin
         c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 126));
         if (c == mtd_pkg::CHAR_EQUALS) c = 8'h7E;
         offer(c, ps, 1'b1);
      end else if (r < 85) begin
         offer(mtd_pkg::CHAR_EQUALS, ps, 1'b1);
         if ($urandom_range(0, 3) == 0) offer(escape_junk(), 1'b0, 1'b0);
         offer(hex_char(), 1'b0, 1'b1);
         if ($urandom_range(0, 4) == 0) offer(escape_junk(), 1'b0, 1'b0);
         offer(hex_char(), 1'b0, 1'b1);
      end else if (r < 93) begin
         offer(mtd_pkg::CHAR_EQUALS, ps, 1'b1);
         offer(hex_char(), 1'b0, 1'b1);
         restart = 1'b1;
      end else begin
         offer(8'($urandom_range(0, 255)), ps || ($urandom_range(0, 7) == 0), 1'b1);
      end
   endtask

   task automatic stream(input logic [1:0] m, input int upto);
      while (random_items < upto) begin
         case (m)
            mtd_pkg::MODE_BASE64: b64_unit();
            mtd_pkg::MODE_QPRINT: qp_unit();
            default: offer(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, 1'b1);
         endcase
      end
   endtask

   initial begin
      int         phase;
      int         target;
      logic [1:0] m;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = mtd_pkg::MODE_PASS;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = 8'h00;
      req_ch.part_start = 1'b0;
      hold_req          = 1'b0;
      hold_cycles       = 0;
      holds_done        = 0;
      burst_left        = 0;
      random_items      = 0;
      modes_written     = 0;
      restart           = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through after reset: byte extremes and a bare '='
      offer(8'h00, 1'b0, 1'b0);
      offer(8'hFF, 1'b0, 1'b0);
      offer(mtd_pkg::CHAR_EQUALS, 1'b0, 1'b0);
      set_mode(mtd_pkg::MODE_BASE64);
      offer_text("TW\nFu");
      offer_text("T=Q=");
      offer_text("A===");
      offer_text("Zm");
      // leave half a group pending across the mode change
      set_mode(mtd_pkg::MODE_QPRINT);
      offer_text("=4z=1q");
      set_mode(mtd_pkg::MODE_BASE64);
      offer_text("Fu");
      set_mode(MODE_SPARE);
      offer(8'h80, 1'b1, 1'b0);

      phase = 0;
      while (random_items < 220) begin
         m = (phase < 8) ? mode_plan[phase] : 2'($urandom_range(0, 3));
         set_mode(m);
         target = random_items + 28;
         if (phase == 1 || phase == 3) begin
            hold_cycles = 90;
            hold_req    = 1'b1;
         end
         stream(m, target - 14);
         if (phase % 3 == 1) settle();
         stream(m, target);
         phase++;
      end
      settle();

      if (board.pending() != 0)
         board.complain($sformatf("%0d decoded beats never arrived", board.pending()));
      $display("covered %0d encoded beats, %0d decoded beats, %0d mode writes",
               board.beats_in, board.beats_out, modes_written);
      $display("%0d long output holds, %0d failures", holds_done, board.failures);
      if (board.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
